// ===== design/kbs_pkg.sv =====
package kbs_pkg;

	// cordic rotation count and step counter width
	localparam int CORDIC_ITERS = 16;
	localparam int CNT_W = 5;
	// top bit of the restoring heading reduction (2pi scaled by 2^9)
	localparam logic [CNT_W-1:0] MOD_TOP = CNT_W'(9);

	// configuration register indexes
	localparam logic [1:0] REG_INV_WHEELBASE = 2'd0;
	localparam logic [1:0] REG_MAX_STEER = 2'd1;
	localparam logic [1:0] REG_MIN_STEER = 2'd2;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CLOAD,
		ST_CITER,
		ST_CSTORE,
		ST_MUL,
		ST_WB,
		ST_MODI,
		ST_MODS,
		ST_COMMIT
	} kbs_state_t;

	typedef enum logic [2:0] {
		OP_D,
		OP_DC,
		OP_DS,
		OP_DX,
		OP_DY,
		OP_DH,
		OP_DT
	} mul_op_t;

	typedef enum logic {
		SEL_TIRE,
		SEL_HEAD
	} cordic_sel_t;

	typedef struct packed {
		logic accept;
		logic c_load;
		logic c_iter;
		logic c_store;
		cordic_sel_t sel;
		logic [CNT_W-1:0] idx;
		logic mul_en;
		logic wb_en;
		mul_op_t op;
		logic mod_init;
		logic mod_step;
		logic commit;
	} kbs_cmd_t;

	// arctangent of 2^-i, truncated Q30
	function automatic logic [29:0] atan_q30(input logic [CNT_W-1:0] i);
		logic [29:0] r;
		unique case (i)
			5'd0: r = 30'd843314856;
			5'd1: r = 30'd497837829;
			5'd2: r = 30'd263043836;
			5'd3: r = 30'd133525158;
			5'd4: r = 30'd67021686;
			5'd5: r = 30'd33543515;
			5'd6: r = 30'd16775850;
			5'd7: r = 30'd8388437;
			5'd8: r = 30'd4194282;
			5'd9: r = 30'd2097149;
			5'd10: r = 30'd1048575;
			5'd11: r = 30'd524287;
			5'd12: r = 30'd262143;
			5'd13: r = 30'd131071;
			5'd14: r = 30'd65535;
			5'd15: r = 30'd32767;
			5'd16: r = 30'd16383;
			5'd17: r = 30'd8191;
			5'd18: r = 30'd4095;
			5'd19: r = 30'd2047;
			5'd20: r = 30'd1023;
			5'd21: r = 30'd511;
			5'd22: r = 30'd255;
			5'd23: r = 30'd127;
			5'd24: r = 30'd63;
			default: r = 30'd0;
		endcase
		return r;
	endfunction

endpackage

// ===== design/kbs_in_if.sv =====
interface kbs_in_if;
	logic valid;
	logic ready;
	logic signed [15:0] steer_rate;
	logic signed [15:0] speed;
	logic [15:0] step_time;
	logic [31:0] input_time;

	modport source (output valid, steer_rate, speed, step_time, input_time, input ready);
	modport sink (input valid, steer_rate, speed, step_time, input_time, output ready);
endinterface

// ===== design/kbs_out_if.sv =====
interface kbs_out_if;
	logic valid;
	logic ready;
	logic signed [31:0] pos_x;
	logic signed [31:0] pos_y;
	logic signed [15:0] steer_angle;
	logic [15:0] heading_angle;
	logic [31:0] out_time;

	modport source (output valid, pos_x, pos_y, steer_angle, heading_angle, out_time,
		input ready);
	modport sink (input valid, pos_x, pos_y, steer_angle, heading_angle, out_time,
		output ready);
endinterface

// ===== design/kbs_cfg_if.sv =====
interface kbs_cfg_if;
	logic valid;
	logic ready;
	logic [1:0] index;
	logic [15:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== design/kbs_ctrl.sv =====
module kbs_ctrl
	import kbs_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input logic out_ready,
	output kbs_cmd_t cmd
);

	kbs_state_t state_q, state_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	cordic_sel_t sel_q, sel_d;
	mul_op_t op_q, op_d;
	logic out_valid_q;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
			sel_q <= SEL_TIRE;
			op_q <= OP_D;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q <= cnt_d;
			sel_q <= sel_d;
			op_q <= op_d;
			if (cmd.commit)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign in_ready = (state_q == ST_IDLE);

	// next state and commands
	always_comb begin
		state_d = state_q;
		cnt_d = cnt_q;
		sel_d = sel_q;
		op_d = op_q;
		cmd = '0;
		cmd.sel = sel_q;
		cmd.idx = cnt_q;
		cmd.op = op_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					sel_d = SEL_TIRE;
					state_d = ST_CLOAD;
				end
			end
			ST_CLOAD: begin
				cmd.c_load = 1'b1;
				cnt_d = '0;
				state_d = ST_CITER;
			end
			ST_CITER: begin
				cmd.c_iter = 1'b1;
				if (cnt_q == CNT_W'(CORDIC_ITERS - 1))
					state_d = ST_CSTORE;
				else
					cnt_d = cnt_q + 1'b1;
			end
			ST_CSTORE: begin
				cmd.c_store = 1'b1;
				if (sel_q == SEL_TIRE) begin
					sel_d = SEL_HEAD;
					state_d = ST_CLOAD;
				end else begin
					op_d = OP_D;
					state_d = ST_MUL;
				end
			end
			ST_MUL: begin
				cmd.mul_en = 1'b1;
				state_d = ST_WB;
			end
			ST_WB: begin
				cmd.wb_en = 1'b1;
				state_d = ST_MUL;
				unique case (op_q)
					OP_D: op_d = OP_DC;
					OP_DC: op_d = OP_DS;
					OP_DS: op_d = OP_DX;
					OP_DX: op_d = OP_DY;
					OP_DY: op_d = OP_DH;
					OP_DH: op_d = OP_DT;
					default: state_d = ST_MODI;
				endcase
			end
			ST_MODI: begin
				cmd.mod_init = 1'b1;
				cnt_d = MOD_TOP;
				state_d = ST_MODS;
			end
			ST_MODS: begin
				cmd.mod_step = 1'b1;
				if (cnt_q == '0)
					state_d = ST_COMMIT;
				else
					cnt_d = cnt_q - 1'b1;
			end
			ST_COMMIT: begin
				if (!out_valid_q || out_ready) begin
					cmd.commit = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

// ===== design/kbs_dp.sv =====
module kbs_dp
	import kbs_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input kbs_cmd_t cmd,
	input logic cfg_we,
	input logic [1:0] cfg_index,
	input logic [15:0] cfg_data,
	input logic signed [15:0] steer_rate,
	input logic signed [15:0] speed,
	input logic [15:0] step_time,
	input logic [31:0] input_time,
	output logic signed [31:0] pos_x,
	output logic signed [31:0] pos_y,
	output logic signed [15:0] steer_angle,
	output logic [15:0] heading_angle,
	output logic [31:0] out_time
);

	localparam logic signed [34:0] PI_Q30 = 35'sd3373259426;
	localparam logic signed [34:0] HALF_PI_Q30 = 35'sd1686629713;
	localparam logic signed [34:0] TWO_PI_Q30 = 35'sd6746518852;
	localparam logic signed [33:0] GAIN_Q30 = 34'sd652032874;
	localparam logic [25:0] TWO_PI_Q13 = 26'd51472;
	localparam logic signed [26:0] MOD_BIAS = 27'sd26353664;

	// round half up then floor shift
	function automatic logic signed [65:0] rshift(input logic signed [65:0] p,
		input int s);
		logic signed [65:0] h;
		h = 66'sd1 <<< (s - 1);
		return (p + h) >>> s;
	endfunction

	// configuration and state
	logic [15:0] iwb_q;
	logic signed [15:0] max_q, min_q;
	logic signed [31:0] x_q, y_q;
	logic signed [15:0] tire_q;
	logic [15:0] head_q;

	// latched item
	logic signed [15:0] rate_q, speed_q;
	logic [15:0] dt_q;
	logic [31:0] tin_q;

	// cordic unit
	logic signed [33:0] cx_q, cy_q;
	logic signed [34:0] cz_q;
	logic flip_q;
	logic signed [31:0] ss_q, cs_q, sh_q, ch_q;

	// multiplier and intermediates
	logic signed [33:0] ma, mb_x;
	logic signed [31:0] mb;
	logic signed [65:0] prod_q;
	logic signed [31:0] d_q;
	logic signed [33:0] dc_q, ds_q;
	logic signed [25:0] dx_q, dy_q, dh_q;
	logic signed [17:0] dtr_q;
	logic [25:0] mod_q;

	// output registers
	logic signed [31:0] ox_q, oy_q;
	logic signed [15:0] ot_q;
	logic [15:0] oh_q;
	logic [31:0] otime_q;

	// cordic load with range fold
	logic signed [16:0] ang17;
	logic signed [34:0] z0, z1, z2;
	always_comb begin
		ang17 = (cmd.sel == SEL_HEAD) ? $signed({1'b0, head_q}) : {tire_q[15], tire_q};
		z0 = {{18{ang17[16]}}, ang17} <<< 17;
		z1 = (z0 > PI_Q30) ? z0 - TWO_PI_Q30 : z0;
		z2 = (z1 < -PI_Q30) ? z1 + TWO_PI_Q30 : z1;
	end

	// cordic rotation step
	logic signed [33:0] xs, ys;
	logic signed [34:0] at;
	assign xs = cx_q >>> cmd.idx;
	assign ys = cy_q >>> cmd.idx;
	assign at = {5'd0, atan_q30(cmd.idx)};

	// multiplier operand select
	always_comb begin
		unique case (cmd.op)
			OP_D: begin ma = 34'(speed_q); mb = {16'd0, dt_q}; end
			OP_DC: begin ma = 34'(d_q); mb = cs_q; end
			OP_DS: begin ma = 34'(d_q); mb = ss_q; end
			OP_DX: begin ma = dc_q; mb = ch_q; end
			OP_DY: begin ma = dc_q; mb = sh_q; end
			OP_DH: begin ma = ds_q; mb = {16'd0, iwb_q}; end
			default: begin ma = 34'(rate_q); mb = {16'd0, dt_q}; end
		endcase
		mb_x = 34'(mb);
	end

	// new state values at commit
	logic signed [32:0] nx, ny;
	logic signed [17:0] nt, mx18, mn18;
	logic signed [26:0] nh;
	always_comb begin
		nx = 33'(x_q) + 33'(dx_q);
		ny = 33'(y_q) + 33'(dy_q);
		nt = 18'(tire_q) + dtr_q;
		mx18 = 18'(max_q);
		mn18 = 18'(min_q);
		nh = $signed({11'd0, head_q}) + 27'(dh_q);
	end

	function automatic logic signed [31:0] sat32(input logic signed [32:0] v);
		if (v[32] != v[31])
			return v[32] ? 32'sh80000000 : 32'sh7fffffff;
		return v[31:0];
	endfunction

	// configuration and vehicle state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iwb_q <= 16'd1638;
			max_q <= 16'sd4096;
			min_q <= -16'sd4096;
			x_q <= '0;
			y_q <= '0;
			tire_q <= '0;
			head_q <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_INV_WHEELBASE: iwb_q <= cfg_data;
					REG_MAX_STEER: max_q <= cfg_data;
					REG_MIN_STEER: min_q <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.commit) begin
				x_q <= sat32(nx);
				y_q <= sat32(ny);
				if (nt > mx18)
					tire_q <= max_q;
				else if (nt < mn18)
					tire_q <= min_q;
				else
					tire_q <= nt[15:0];
				head_q <= mod_q[15:0];
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			rate_q <= steer_rate;
			speed_q <= speed;
			dt_q <= step_time;
			tin_q <= input_time;
		end
		if (cmd.c_load) begin
			cx_q <= GAIN_Q30;
			cy_q <= '0;
			if (z2 > HALF_PI_Q30) begin
				cz_q <= z2 - PI_Q30;
				flip_q <= 1'b1;
			end else if (z2 < -HALF_PI_Q30) begin
				cz_q <= z2 + PI_Q30;
				flip_q <= 1'b1;
			end else begin
				cz_q <= z2;
				flip_q <= 1'b0;
			end
		end
		if (cmd.c_iter) begin
			if (!cz_q[34]) begin
				cx_q <= cx_q - ys;
				cy_q <= cy_q + xs;
				cz_q <= cz_q - at;
			end else begin
				cx_q <= cx_q + ys;
				cy_q <= cy_q - xs;
				cz_q <= cz_q + at;
			end
		end
		if (cmd.c_store) begin
			if (cmd.sel == SEL_TIRE) begin
				ss_q <= flip_q ? 32'(-cy_q) : cy_q[31:0];
				cs_q <= flip_q ? 32'(-cx_q) : cx_q[31:0];
			end else begin
				sh_q <= flip_q ? 32'(-cy_q) : cy_q[31:0];
				ch_q <= flip_q ? 32'(-cx_q) : cx_q[31:0];
			end
		end
		if (cmd.mul_en)
			prod_q <= 66'(ma) * 66'(mb_x);
		if (cmd.wb_en) begin
			unique case (cmd.op)
				OP_D: d_q <= prod_q[31:0];
				OP_DC: dc_q <= 34'(rshift(prod_q, 30));
				OP_DS: ds_q <= 34'(rshift(prod_q, 30));
				OP_DX: dx_q <= 26'(rshift(prod_q, 38));
				OP_DY: dy_q <= 26'(rshift(prod_q, 38));
				OP_DH: dh_q <= 26'(rshift(prod_q, 23));
				default: dtr_q <= 18'(rshift(prod_q, 16));
			endcase
		end
		// heading reduction, restoring subtract of 2pi scaled
		if (cmd.mod_init)
			mod_q <= nh[26] ? 26'(nh + MOD_BIAS) : nh[25:0];
		if (cmd.mod_step) begin
			if (mod_q >= (TWO_PI_Q13 << cmd.idx))
				mod_q <= mod_q - (TWO_PI_Q13 << cmd.idx);
		end
		if (cmd.commit) begin
			ox_q <= sat32(nx);
			oy_q <= sat32(ny);
			if (nt > mx18)
				ot_q <= max_q;
			else if (nt < mn18)
				ot_q <= min_q;
			else
				ot_q <= nt[15:0];
			oh_q <= mod_q[15:0];
			otime_q <= tin_q + {16'd0, dt_q};
		end
	end

	assign pos_x = ox_q;
	assign pos_y = oy_q;
	assign steer_angle = ot_q;
	assign heading_angle = oh_q;
	assign out_time = otime_q;

endmodule

// ===== design/kinematic_bicycle_step_core.sv =====
// channel | role        | beat contents
// cfg     | config sink | index, data (always ready)
// req     | input sink  | steer_rate, speed, step_time, input_time
// rsp     | output src  | pos_x, pos_y, steer_angle, heading_angle, out_time
//
// one item at a time: a new request is taken only once the last one is committed;
// each item makes two passes through the shared cordic unit, seven products
// on the single multiplier (multiply, then write back) and the heading reduction
// reset clears position, tire angle and heading and loads the default registers
// the finished beat waits in the output register while the next item is taken
module kinematic_bicycle_step_core
	import kbs_pkg::*;
(
	input logic clk,
	input logic arst_n,
	kbs_cfg_if.sink cfg,
	kbs_in_if.sink req,
	kbs_out_if.source rsp
);

	kbs_cmd_t cmd;

	assign cfg.ready = 1'b1;

	// sequencer
	kbs_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(req.valid),
		.in_ready(req.ready),
		.out_valid(rsp.valid),
		.out_ready(rsp.ready),
		.cmd(cmd)
	);

	// arithmetic and state
	kbs_dp u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.cfg_we(cfg.valid),
		.cfg_index(cfg.index),
		.cfg_data(cfg.data),
		.steer_rate(req.steer_rate),
		.speed(req.speed),
		.step_time(req.step_time),
		.input_time(req.input_time),
		.pos_x(rsp.pos_x),
		.pos_y(rsp.pos_y),
		.steer_angle(rsp.steer_angle),
		.heading_angle(rsp.heading_angle),
		.out_time(rsp.out_time)
	);

endmodule

// ===== tb/testbench.sv =====
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import kbs_pkg::*;

	localparam longint PI_Q30 = 64'sd3373259426;
	localparam longint HALF_PI_Q30 = 64'sd1686629713;
	localparam longint TWO_PI_Q30 = 64'sd6746518852;
	localparam longint CORDIC_GAIN = 64'sd652032874;
	localparam longint TWO_PI_Q13 = 64'sd51472;
	localparam int STALL_LIMIT = 4000;

	typedef struct packed {
		logic signed [15:0] steer_rate;
		logic signed [15:0] speed;
		logic [15:0] step_time;
		logic [31:0] input_time;
	} motion_cmd_t;

	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [15:0] steer_angle;
		logic [15:0] heading_angle;
		logic [31:0] out_time;
	} pose_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	kbs_cfg_if cfg_if ();
	kbs_in_if req_if ();
	kbs_out_if rsp_if ();

	kinematic_bicycle_step_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_if),
		.req(req_if),
		.rsp(rsp_if)
	);

	always #6 clk = ~clk;

	motion_cmd_t pending_cmds[$];
	pose_t expected_poses[$];
	int errors = 0;
	int send_gap = 0;
	int idle_cycles = 0;

	// shadow of the vehicle state and registers
	logic [15:0] inv_wheelbase = 16'd1638;
	logic signed [15:0] max_steer = 16'sd4096;
	logic signed [15:0] min_steer = -16'sd4096;
	logic signed [31:0] x_pos = '0;
	logic signed [31:0] y_pos = '0;
	logic signed [15:0] tire_ang = '0;
	logic [15:0] head_ang = '0;

	function automatic longint rnd_shift(input longint v, input int s);
		longint t;
		t = v + (longint'(1) <<< (s - 1));
		return t >>> s;
	endfunction

	// cordic rotation from a Q3.13 angle, results in Q30
	task automatic angle_sincos(input longint ang, output longint sn, output longint cs);
		longint z, xa, ya, nx, xs, ys;
		bit flip;
		z = ang * 131072;
		xa = CORDIC_GAIN;
		ya = 0;
		flip = 0;
		if (z > PI_Q30) z -= TWO_PI_Q30;
		if (z < -PI_Q30) z += TWO_PI_Q30;
		if (z > HALF_PI_Q30) begin
			z -= PI_Q30;
			flip = 1;
		end else if (z < -HALF_PI_Q30) begin
			z += PI_Q30;
			flip = 1;
		end
		for (int i = 0; i < CORDIC_ITERS; i++) begin
			xs = xa >>> i;
			ys = ya >>> i;
			if (z >= 0) begin
				nx = xa - ys;
				ya = ya + xs;
				z -= longint'(atan_q30(CNT_W'(i)));
			end else begin
				nx = xa + ys;
				ya = ya - xs;
				z += longint'(atan_q30(CNT_W'(i)));
			end
			xa = nx;
		end
		if (flip) begin
			xa = -xa;
			ya = -ya;
		end
		sn = ya;
		cs = xa;
	endtask

	// one euler step of the shadow state
	task automatic advance_pose(input motion_cmd_t c);
		longint ss, cs, sh, ch, d, dc, ds, nx, ny, nh, nt;
		pose_t p;
		angle_sincos(longint'(tire_ang), ss, cs);
		angle_sincos(longint'(head_ang), sh, ch);
		d = longint'(c.speed) * longint'(c.step_time);
		dc = rnd_shift(d * cs, 30);
		ds = rnd_shift(d * ss, 30);
		nx = longint'(x_pos) + rnd_shift(dc * ch, 38);
		ny = longint'(y_pos) + rnd_shift(dc * sh, 38);
		nh = longint'(head_ang) + rnd_shift(ds * longint'(inv_wheelbase), 23);
		nh = nh % TWO_PI_Q13;
		if (nh < 0) nh += TWO_PI_Q13;
		nt = longint'(tire_ang) + rnd_shift(longint'(c.steer_rate) * longint'(c.step_time), 16);
		if (nt > max_steer) nt = max_steer;
		else if (nt < min_steer) nt = min_steer;
		x_pos = (nx > 64'sd2147483647) ? 32'sh7fffffff :
			(nx < -64'sd2147483648) ? 32'sh80000000 : nx[31:0];
		y_pos = (ny > 64'sd2147483647) ? 32'sh7fffffff :
			(ny < -64'sd2147483648) ? 32'sh80000000 : ny[31:0];
		tire_ang = nt[15:0];
		head_ang = nh[15:0];
		p.pos_x = x_pos;
		p.pos_y = y_pos;
		p.steer_angle = tire_ang;
		p.heading_angle = head_ang;
		p.out_time = c.input_time + 32'(c.step_time);
		expected_poses.push_back(p);
	endtask

	task automatic report(input string what, input longint got, input longint want);
		errors++;
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
	endtask

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 95) return $urandom_range(1, 4);
		return $urandom_range(20, 80);
	endfunction

	// request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_if.valid <= 1'b0;
			req_if.steer_rate <= '0;
			req_if.speed <= '0;
			req_if.step_time <= '0;
			req_if.input_time <= '0;
			send_gap <= 0;
		end else begin
			if (req_if.valid && req_if.ready)
				advance_pose({req_if.steer_rate, req_if.speed, req_if.step_time,
					req_if.input_time});
			if (req_if.valid && !req_if.ready) begin
				// hold the beat
			end else if (send_gap != 0) begin
				req_if.valid <= 1'b0;
				send_gap <= send_gap - 1;
			end else if (pending_cmds.size() != 0) begin
				motion_cmd_t c;
				c = pending_cmds.pop_front();
				req_if.valid <= 1'b1;
				req_if.steer_rate <= c.steer_rate;
				req_if.speed <= c.speed;
				req_if.step_time <= c.step_time;
				req_if.input_time <= c.input_time;
				send_gap <= pick_gap();
			end else begin
				req_if.valid <= 1'b0;
			end
		end
	end

	// response monitor with random back-pressure
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_if.ready <= 1'b0;
		end else begin
			if (rsp_if.valid && rsp_if.ready) begin
				if (expected_poses.size() == 0) begin
					report("unexpected beat pos_x", rsp_if.pos_x, 0);
				end else begin
					pose_t e;
					e = expected_poses.pop_front();
					if (rsp_if.pos_x !== e.pos_x) report("pos_x", rsp_if.pos_x, e.pos_x);
					if (rsp_if.pos_y !== e.pos_y) report("pos_y", rsp_if.pos_y, e.pos_y);
					if (rsp_if.steer_angle !== e.steer_angle)
						report("steer_angle", rsp_if.steer_angle, e.steer_angle);
					if (rsp_if.heading_angle !== e.heading_angle)
						report("heading_angle", rsp_if.heading_angle, e.heading_angle);
					if (rsp_if.out_time !== e.out_time)
						report("out_time", rsp_if.out_time, e.out_time);
				end
			end
			rsp_if.ready <= (pick_gap() == 0);
		end
	end

	// register shadow
	always @(posedge clk) begin
		if (arst_n && cfg_if.valid && cfg_if.ready) begin
			case (cfg_if.index)
				REG_INV_WHEELBASE: inv_wheelbase = cfg_if.data;
				REG_MAX_STEER: max_steer = cfg_if.data;
				REG_MIN_STEER: min_steer = cfg_if.data;
				default: ;
			endcase
		end
	end

	// watchdog on beats of any channel
	always @(posedge clk) begin
		if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)
				|| (cfg_if.valid && cfg_if.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("kinematic_bicycle_step_core test failed");
			$finish;
		end
	end

	// one register beat, with valid dropped before the next
	task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
		cfg_if.valid <= 1'b1;
		cfg_if.index <= idx;
		cfg_if.data <= val;
		@(posedge clk);
		while (!cfg_if.ready) @(posedge clk);
		cfg_if.valid <= 1'b0;
		@(posedge clk);
	endtask

	// wait until the block has drained, then let it settle
	task automatic drain();
		while (pending_cmds.size() != 0 || req_if.valid || expected_poses.size() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	task automatic queue_cmd(input logic [15:0] rate, input logic [15:0] spd,
			input logic [15:0] dt, input logic [31:0] t);
		pending_cmds.push_back({rate, spd, dt, t});
	endtask

	task automatic queue_random(input int n, input bit fast);
		motion_cmd_t c;
		repeat (n) begin
			c.steer_rate = 16'($urandom);
			c.speed = 16'($urandom);
			c.step_time = 16'($urandom);
			c.input_time = 32'($urandom);
			if (fast) begin
				c.speed = ($urandom_range(0, 1) != 0) ? 16'sh7fff : 16'sh8000;
				c.step_time = 16'hffff - 16'($urandom_range(0, 255));
			end
			pending_cmds.push_back(c);
		end
	endtask

	initial begin
		cfg_if.valid = 1'b0;
		cfg_if.index = '0;
		cfg_if.data = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: field extremes, clamps, heading wrap both ways
		queue_cmd(16'h0000, 16'h0000, 16'h0000, 32'h0000_0000);
		queue_cmd(16'h7fff, 16'h7fff, 16'hffff, 32'hffff_ffff);
		queue_cmd(16'h8000, 16'h8000, 16'hffff, 32'hffff_0000);
		queue_cmd(16'h8000, 16'h7fff, 16'hffff, 32'h0000_ffff);
		queue_cmd(16'h7fff, 16'h8000, 16'h0001, 32'h8000_0000);
		queue_cmd(16'h7fff, 16'h7fff, 16'hffff, 32'h7fff_ffff);
		queue_cmd(16'h0000, 16'h7fff, 16'hffff, 32'h1234_5678);
		queue_cmd(16'h0000, 16'h8000, 16'hffff, 32'h0000_0001);
		queue_cmd(16'h8000, 16'h8000, 16'hffff, 32'hfffe_ffff);
		queue_cmd(16'h0000, 16'h8000, 16'hffff, 32'h5555_aaaa);
		queue_cmd(16'h0001, 16'h0001, 16'h0001, 32'haaaa_5555);
		queue_cmd(16'hffff, 16'hffff, 16'h8000, 32'h0000_8000);
		drain();

		// wide limits, largest wheelbase inverse
		write_reg(REG_INV_WHEELBASE, 16'hffff);
		write_reg(REG_MAX_STEER, 16'h7fff);
		write_reg(REG_MIN_STEER, 16'h8000);
		queue_cmd(16'h7fff, 16'h0000, 16'hffff, 32'h0);
		queue_cmd(16'h7fff, 16'h0000, 16'hffff, 32'h0);
		queue_cmd(16'h7fff, 16'h7fff, 16'hffff, 32'h0);
		queue_cmd(16'h8000, 16'h8000, 16'hffff, 32'h0);
		queue_random(300, 0);
		drain();

		// straight runs at top speed to reach position saturation
		write_reg(REG_MAX_STEER, 16'h0000);
		write_reg(REG_MIN_STEER, 16'h0000);
		write_reg(REG_INV_WHEELBASE, 16'h0000);
		queue_random(300, 1);
		drain();

		// min above max, smallest nonzero wheelbase inverse
		write_reg(REG_INV_WHEELBASE, 16'h0001);
		write_reg(REG_MAX_STEER, 16'hf000);
		write_reg(REG_MIN_STEER, 16'h1000);
		queue_random(150, 0);
		drain();

		// random registers, then back to defaults
		write_reg(REG_INV_WHEELBASE, 16'($urandom_range(1, 65535)));
		write_reg(REG_MAX_STEER, 16'($urandom_range(4096, 32767)));
		write_reg(REG_MIN_STEER, 16'(-$urandom_range(4096, 32768)));
		queue_random(250, 0);
		drain();
		write_reg(REG_INV_WHEELBASE, 16'd1638);
		write_reg(REG_MAX_STEER, 16'd4096);
		write_reg(REG_MIN_STEER, 16'hf000);
		queue_random(200, 0);
		drain();

		if (errors == 0)
			$display("kinematic_bicycle_step_core test passed");
		else
			$display("kinematic_bicycle_step_core test failed");
		$finish;
	end
endmodule
